/* sv/smft_pkg.sv */
// ----------------------------------------------------------------------------
// smft_pkg
// Shared widths, codes and types for the sparse matrix fast transpose block.
// ----------------------------------------------------------------------------
package smft_pkg;

	// fixed field widths
	localparam int IDX_W   = 4;
	localparam int VAL_W   = 32;
	localparam int DIM_W   = 5;
	localparam int COUNT_W = 7;
	localparam int ERR_W   = 2;

	// parameter defaults
	localparam int DEF_MAX_TERMS = 64;
	localparam int DEF_MAX_DIM   = 16;

	// columns an index field can address at all
	localparam int COL_LIMIT = 2 ** IDX_W;

	// dimension register reset value
	localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(16);

	// error codes
	localparam logic [ERR_W-1:0] ERR_OK  = 2'd0;
	localparam logic [ERR_W-1:0] ERR_CAP = 2'd1;
	localparam logic [ERR_W-1:0] ERR_IDX = 2'd2;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = 1'b1;

	// one stored triple
	typedef struct packed {
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic [VAL_W-1:0] value;
	} smft_term_t;

	// controller to datapath
	typedef struct packed {
		logic load;     // beat accepted
		logic clear;    // drop per-load state
		logic idx_clr;  // restart sweep counter
		logic idx_inc;  // advance sweep counter
		logic prefix;   // prefix sum step
		logic sc_rd;    // scatter read of source store
		logic emit_rd;  // emit read of result store
	} smft_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic nonempty;  // store holds a term once this beat is taken
		logic col_end;   // sweep counter at last column
		logic term_end;  // sweep counter at last stored term
	} smft_sts_t;

endpackage

/* sv/smft_ctrl.sv */
// ----------------------------------------------------------------------------
// smft_ctrl
// Phase sequencer: load, prefix sum, scatter, emit.
// ----------------------------------------------------------------------------
module smft_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                last,
	input  smft_pkg::smft_sts_t sts,
	output smft_pkg::smft_cmd_t cmd,
	output logic                busy
);
	import smft_pkg::*;

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_PREFIX  = 3'd1;
	localparam logic [2:0] S_SCATTER = 3'd2;
	localparam logic [2:0] S_SC_TAIL = 3'd3;
	localparam logic [2:0] S_EMIT    = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_nxt;
	logic       accept;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	// next state and commands
	always_comb begin
		state_nxt   = state_q;
		cmd         = '0;
		case (state_q)
			S_IDLE: begin
				cmd.load    = accept;
				cmd.idx_clr = 1'b1;
				if (accept && last) begin
					if (sts.nonempty) begin
						state_nxt = S_PREFIX;
					end else begin
						cmd.clear = 1'b1;
					end
				end
			end
			S_PREFIX: begin
				cmd.prefix = 1'b1;
				if (sts.col_end) begin
					cmd.idx_clr = 1'b1;
					state_nxt   = S_SCATTER;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			S_SCATTER: begin
				cmd.sc_rd = 1'b1;
				if (sts.term_end) begin
					cmd.idx_clr = 1'b1;
					state_nxt   = S_SC_TAIL;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			S_SC_TAIL: begin
				// last scatter write lands here
				state_nxt = S_EMIT;
			end
			S_EMIT: begin
				cmd.emit_rd = 1'b1;
				if (sts.term_end) begin
					cmd.clear = 1'b1;
					state_nxt = S_IDLE;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

/* sv/smft_dp.sv */
// ----------------------------------------------------------------------------
// smft_dp
// Term stores, column counters, start positions and output registers.
// ----------------------------------------------------------------------------
module smft_dp #(
	parameter int MAX_TERMS = smft_pkg::DEF_MAX_TERMS,
	parameter int MAX_DIM   = smft_pkg::DEF_MAX_DIM
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  smft_pkg::smft_cmd_t                 cmd,
	output smft_pkg::smft_sts_t                 sts,
	input  logic                                cfg_we,
	input  logic [smft_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [smft_pkg::DIM_W-1:0]          cfg_wdata,
	input  logic [smft_pkg::IDX_W-1:0]          term_row,
	input  logic [smft_pkg::IDX_W-1:0]          term_col,
	input  logic signed [smft_pkg::VAL_W-1:0]   term_value,
	input  logic                                has_term,
	output logic                                result_valid,
	output logic [smft_pkg::IDX_W-1:0]          out_row,
	output logic [smft_pkg::IDX_W-1:0]          out_col,
	output logic signed [smft_pkg::VAL_W-1:0]   out_value,
	output logic [smft_pkg::COUNT_W-1:0]        term_count,
	output logic [smft_pkg::ERR_W-1:0]          error,
	output logic                                end_of_run
);
	import smft_pkg::*;

	localparam int NCOL   = (MAX_DIM < COL_LIMIT) ? MAX_DIM : COL_LIMIT;
	localparam int COL_W  = $clog2(NCOL);
	localparam int CNT_W  = $clog2(MAX_TERMS + 1);
	localparam int ADDR_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
	localparam int SW_W   = (ADDR_W > COL_W) ? ADDR_W : COL_W;
	localparam int CMP_W  = (SW_W > CNT_W) ? SW_W : CNT_W;

	// configuration
	logic [DIM_W-1:0] num_rows_q;
	logic [DIM_W-1:0] num_cols_q;

	// per-load state
	logic [CNT_W-1:0] stored_q;
	logic [ERR_W-1:0] err_q;
	logic [ERR_W-1:0] err_nxt;
	logic [CNT_W-1:0] cnt_q [NCOL];
	logic [CNT_W-1:0] start_q [NCOL];
	logic [CNT_W-1:0] acc_q;
	logic [SW_W-1:0]  idx_q;

	// stores
	smft_term_t src_mem [MAX_TERMS];
	smft_term_t res_mem [MAX_TERMS];

	// scatter stage
	smft_term_t       src_rd_s1;
	logic             sc_vld_s1;
	logic [COL_W-1:0] sc_col;
	logic [CNT_W-1:0] sc_pos;

	// output registers
	smft_term_t         res_rd_q;
	logic               out_vld_q;
	logic               eor_q;
	logic [COUNT_W-1:0] out_cnt_q;
	logic [ERR_W-1:0]   out_err_q;

	logic             row_ok;
	logic             col_ok;
	logic             full;
	logic             store;
	logic [COL_W-1:0] cnt_addr;
	logic [CNT_W-1:0] cnt_rd;

	// index check against current dimensions, capped at MAX_DIM
	assign row_ok = ({1'b0, term_row} < num_rows_q) && (32'(term_row) < MAX_DIM);
	assign col_ok = ({1'b0, term_col} < num_cols_q) && (32'(term_col) < MAX_DIM);
	assign full   = (stored_q == CNT_W'(MAX_TERMS));
	assign store  = cmd.load && has_term && row_ok && col_ok && !full;

	// sticky error code
	always_comb begin
		err_nxt = err_q;
		if (has_term) begin
			if (!(row_ok && col_ok)) begin
				err_nxt = ERR_IDX;
			end else if (full && (err_q == ERR_OK)) begin
				err_nxt = ERR_CAP;
			end
		end
	end

	// column counter read port, shared by load and prefix
	assign cnt_addr = cmd.prefix ? idx_q[COL_W-1:0] : term_col[COL_W-1:0];
	assign cnt_rd   = cnt_q[cnt_addr];

	// status
	assign sts.nonempty = (stored_q != '0) || store;
	assign sts.col_end  = (idx_q == SW_W'(NCOL - 1));
	assign sts.term_end = (CMP_W'(idx_q) == (CMP_W'(stored_q) - CMP_W'(1)));

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q <= DIM_RESET;
			num_cols_q <= DIM_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_NUM_ROWS: num_rows_q <= cfg_wdata;
				CFG_NUM_COLS: num_cols_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// load bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_q <= '0;
			err_q    <= ERR_OK;
			cnt_q    <= '{default: '0};
		end else if (cmd.clear) begin
			stored_q <= '0;
			err_q    <= ERR_OK;
			cnt_q    <= '{default: '0};
		end else if (cmd.load) begin
			err_q <= err_nxt;
			if (store) begin
				stored_q         <= stored_q + CNT_W'(1);
				cnt_q[cnt_addr]  <= cnt_rd + CNT_W'(1);
			end
		end
	end

	// source store write
	always_ff @(posedge clk) begin
		if (store) begin
			src_mem[stored_q[ADDR_W-1:0]] <= '{row: term_row, col: term_col, value: term_value};
		end
	end

	// sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.idx_clr) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + SW_W'(1);
		end
	end

	// prefix accumulator
	always_ff @(posedge clk) begin
		if (cmd.prefix) begin
			acc_q <= acc_q + cnt_rd;
		end else if (cmd.idx_clr) begin
			acc_q <= '0;
		end
	end

	// start positions: set by prefix, bumped by scatter
	assign sc_col = src_rd_s1.col[COL_W-1:0];
	assign sc_pos = start_q[sc_col];

	always_ff @(posedge clk) begin
		if (cmd.prefix) begin
			start_q[idx_q[COL_W-1:0]] <= acc_q;
		end else if (sc_vld_s1) begin
			start_q[sc_col] <= sc_pos + CNT_W'(1);
		end
	end

	// scatter read stage
	always_ff @(posedge clk) begin
		if (cmd.sc_rd) begin
			src_rd_s1 <= src_mem[idx_q[ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sc_vld_s1 <= 1'b0;
		end else begin
			sc_vld_s1 <= cmd.sc_rd;
		end
	end

	// scatter write with row and column swapped
	always_ff @(posedge clk) begin
		if (sc_vld_s1) begin
			res_mem[sc_pos[ADDR_W-1:0]] <= '{row: src_rd_s1.col, col: src_rd_s1.row,
				value: src_rd_s1.value};
		end
	end

	// emit read into output registers
	always_ff @(posedge clk) begin
		if (cmd.emit_rd) begin
			res_rd_q  <= res_mem[idx_q[ADDR_W-1:0]];
			out_cnt_q <= COUNT_W'(stored_q);
			out_err_q <= err_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			eor_q     <= 1'b0;
		end else begin
			out_vld_q <= cmd.emit_rd;
			eor_q     <= cmd.emit_rd && sts.term_end;
		end
	end

	assign result_valid = out_vld_q;
	assign out_row      = res_rd_q.row;
	assign out_col      = res_rd_q.col;
	assign out_value    = res_rd_q.value;
	assign term_count   = out_cnt_q;
	assign error        = out_err_q;
	assign end_of_run   = eor_q;

	// store never overfills
	a_stored_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stored_q <= CNT_W'(MAX_TERMS))
		else $error("stored term count above capacity");

	// prefix sum covers every stored term
	a_prefix_total: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.prefix && sts.col_end) |=> (acc_q == stored_q))
		else $error("prefix total differs from stored count");

	// scatter slot stays inside the stored range
	a_scatter_pos: assert property (@(posedge clk) disable iff (!arst_n)
		sc_vld_s1 |-> (sc_pos < stored_q))
		else $error("scatter position out of range");

endmodule

/* sv/sparse_matrix_fast_transpose.sv */
// ----------------------------------------------------------------------------
// sparse_matrix_fast_transpose
// Transposes a sparse matrix given as (row, column, value) triples.
// ----------------------------------------------------------------------------
// Terms load at one beat per cycle while busy is low. A beat with last set and
// at least one stored term starts the transpose and raises busy until the last
// emit read. The prefix sum walks the NCOL = min(MAX_DIM, 16) column counters
// one per cycle, the scatter moves one term per cycle through the source store
// read port, and the emit reads one term per cycle from the result store.
// Results come out one per cycle in an unbroken run, each marked by result_valid
// for one cycle; the receiver cannot stall them, so it must take every result
// beat when it appears. A last beat with no stored term gives no result and
// leaves busy low. Dimension registers may be written whenever busy is low.
module sparse_matrix_fast_transpose #(
	parameter int MAX_TERMS = smft_pkg::DEF_MAX_TERMS,
	parameter int MAX_DIM   = smft_pkg::DEF_MAX_DIM
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [smft_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [smft_pkg::DIM_W-1:0]        cfg_wdata,
	input  logic                              start,
	output logic                              busy,
	input  logic [smft_pkg::IDX_W-1:0]        term_row,
	input  logic [smft_pkg::IDX_W-1:0]        term_col,
	input  logic signed [smft_pkg::VAL_W-1:0] term_value,
	input  logic                              has_term,
	input  logic                              last,
	output logic                              result_valid,
	output logic [smft_pkg::IDX_W-1:0]        out_row,
	output logic [smft_pkg::IDX_W-1:0]        out_col,
	output logic signed [smft_pkg::VAL_W-1:0] out_value,
	output logic [smft_pkg::COUNT_W-1:0]      term_count,
	output logic [smft_pkg::ERR_W-1:0]        error,
	output logic                              end_of_run
);
	import smft_pkg::*;

	smft_cmd_t cmd;
	smft_sts_t sts;

	// phase sequencer
	smft_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.last   (last),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// stores and arithmetic
	smft_dp #(
		.MAX_TERMS (MAX_TERMS),
		.MAX_DIM   (MAX_DIM)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_wdata    (cfg_wdata),
		.term_row     (term_row),
		.term_col     (term_col),
		.term_value   (term_value),
		.has_term     (has_term),
		.result_valid (result_valid),
		.out_row      (out_row),
		.out_col      (out_col),
		.out_value    (out_value),
		.term_count   (term_count),
		.error        (error),
		.end_of_run   (end_of_run)
	);

endmodule

/* test/sparse_matrix_fast_transpose_chk.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sparse_matrix_fast_transpose_chk
// Watches the register port, the term beats and the result beats of the block.
// It keeps its own copy of the load state, builds the transposed triples when a
// last beat is taken and compares every result beat against the oldest one.
// ----------------------------------------------------------------------------
module sparse_matrix_fast_transpose_chk
	import smft_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_idx,
	input  logic [DIM_W-1:0]         cfg_wdata,
	input  logic                     start,
	input  logic                     busy,
	input  logic [IDX_W-1:0]         term_row,
	input  logic [IDX_W-1:0]         term_col,
	input  logic signed [VAL_W-1:0]  term_value,
	input  logic                     has_term,
	input  logic                     last,
	input  logic                     result_valid,
	input  logic [IDX_W-1:0]         out_row,
	input  logic [IDX_W-1:0]         out_col,
	input  logic signed [VAL_W-1:0]  out_value,
	input  logic [COUNT_W-1:0]       term_count,
	input  logic [ERR_W-1:0]         error,
	input  logic                     end_of_run,
	output int                       pending,
	output int                       fail_count
);

	// one transposed triple as it should leave the block
	typedef struct {
		logic [IDX_W-1:0]        row;
		logic [IDX_W-1:0]        col;
		logic signed [VAL_W-1:0] value;
		logic [COUNT_W-1:0]      count;
		logic [ERR_W-1:0]        err;
		logic                    eor;
	} xpose_beat_t;

	logic [DIM_W-1:0] rows_reg;
	logic [DIM_W-1:0] cols_reg;
	smft_term_t       load_terms[$];
	logic [ERR_W-1:0] load_err;
	xpose_beat_t      xpose_q[$];
	int               mismatches = 0;

	assign fail_count = mismatches;

	// dimension register clipped to the index range
	function automatic int unsigned dim_limit(input logic [DIM_W-1:0] reg_val);
		return (32'(reg_val) < DEF_MAX_DIM) ? 32'(reg_val) : 32'(DEF_MAX_DIM);
	endfunction

	task automatic report_mismatch(input string what, input logic [VAL_W-1:0] got,
			input logic [VAL_W-1:0] want);
		mismatches++;
		$display("%0t ns mismatch: %s got %0h want %0h", $time, what, got, want);
	endtask

	// store one term, or drop it and raise the sticky error code
	task automatic take_term(input logic [IDX_W-1:0] r, input logic [IDX_W-1:0] c,
			input logic [VAL_W-1:0] v);
		smft_term_t t;
		if (32'(r) >= dim_limit(rows_reg) || 32'(c) >= dim_limit(cols_reg)) begin
			load_err = ERR_IDX;
		end else if (load_terms.size() >= DEF_MAX_TERMS) begin
			if (load_err == ERR_OK)
				load_err = ERR_CAP;
		end else begin
			t.row   = r;
			t.col   = c;
			t.value = v;
			load_terms.push_back(t);
		end
	endtask

	// column tally, prefix sum and stable scatter, then queue the transposed beats
	task automatic build_transpose();
		int          tally[DEF_MAX_DIM];
		int          slot[DEF_MAX_DIM];
		smft_term_t  placed[DEF_MAX_TERMS];
		xpose_beat_t b;
		int          n;
		int          pos;
		n = load_terms.size();
		if (n != 0) begin
			foreach (tally[i])
				tally[i] = 0;
			foreach (load_terms[i])
				tally[load_terms[i].col]++;
			slot[0] = 0;
			for (int i = 1; i < DEF_MAX_DIM; i++)
				slot[i] = slot[i-1] + tally[i-1];
			foreach (load_terms[i]) begin
				pos = slot[load_terms[i].col];
				slot[load_terms[i].col] = pos + 1;
				placed[pos] = load_terms[i];
			end
			for (int i = 0; i < n; i++) begin
				b.row   = placed[i].col;
				b.col   = placed[i].row;
				b.value = placed[i].value;
				b.count = COUNT_W'(n);
				b.err   = load_err;
				b.eor   = (i == n - 1);
				xpose_q.push_back(b);
			end
		end
		load_terms.delete();
		load_err = ERR_OK;
	endtask

	// result compare, term beats and register writes, all on the clock edge
	always @(posedge clk or negedge arst_n) begin
		xpose_beat_t want;
		if (!arst_n) begin
			rows_reg = DIM_RESET;
			cols_reg = DIM_RESET;
			load_err = ERR_OK;
			load_terms.delete();
			xpose_q.delete();
			pending <= 0;
		end else begin
			if (result_valid) begin
				if (xpose_q.size() == 0) begin
					report_mismatch("result beat with none due, out_value", out_value, '0);
				end else begin
					want = xpose_q.pop_front();
					if (out_row !== want.row)
						report_mismatch("out_row", VAL_W'(out_row), VAL_W'(want.row));
					if (out_col !== want.col)
						report_mismatch("out_col", VAL_W'(out_col), VAL_W'(want.col));
					if (out_value !== want.value)
						report_mismatch("out_value", out_value, want.value);
					if (term_count !== want.count)
						report_mismatch("term_count", VAL_W'(term_count),
							VAL_W'(want.count));
					if (error !== want.err)
						report_mismatch("error", VAL_W'(error), VAL_W'(want.err));
					if (end_of_run !== want.eor)
						report_mismatch("end_of_run", VAL_W'(end_of_run),
							VAL_W'(want.eor));
				end
			end
			// a beat taken at this edge still sees the old dimensions
			if (start && !busy) begin
				if (has_term)
					take_term(term_row, term_col, term_value);
				if (last)
					build_transpose();
			end
			if (cfg_we) begin
				if (cfg_idx == CFG_NUM_ROWS)
					rows_reg = cfg_wdata;
				else if (cfg_idx == CFG_NUM_COLS)
					cols_reg = cfg_wdata;
			end
			pending <= xpose_q.size();
		end
	end

endmodule

/* test/sparse_matrix_fast_transpose_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sparse_matrix_fast_transpose_tb
// Drives term loads and dimension writes into the transpose block.
// A directed part hits the value and index extremes, dropped terms, empty
// loads and a dimension change inside a load; random loads with random gaps
// follow, a few of them long enough to overflow the term store.
// ----------------------------------------------------------------------------
module sparse_matrix_fast_transpose_tb;
	import smft_pkg::*;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]     cfg_idx = CFG_NUM_ROWS;
	logic [DIM_W-1:0]         cfg_wdata = '0;
	logic                     start = 1'b0;
	logic                     busy;
	logic [IDX_W-1:0]         term_row = '0;
	logic [IDX_W-1:0]         term_col = '0;
	logic signed [VAL_W-1:0]  term_value = '0;
	logic                     has_term = 1'b0;
	logic                     last = 1'b0;
	logic                     result_valid;
	logic [IDX_W-1:0]         out_row;
	logic [IDX_W-1:0]         out_col;
	logic signed [VAL_W-1:0]  out_value;
	logic [COUNT_W-1:0]       term_count;
	logic [ERR_W-1:0]         error;
	logic                     end_of_run;
	int                       pending;
	int                       fail_count;

	bit                       burst = 1'b0;
	int                       eff_rows = DEF_MAX_DIM;
	int                       eff_cols = DEF_MAX_DIM;
	int                       beats_sent = 0;

	sparse_matrix_fast_transpose u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_wdata    (cfg_wdata),
		.start        (start),
		.busy         (busy),
		.term_row     (term_row),
		.term_col     (term_col),
		.term_value   (term_value),
		.has_term     (has_term),
		.last         (last),
		.result_valid (result_valid),
		.out_row      (out_row),
		.out_col      (out_col),
		.out_value    (out_value),
		.term_count   (term_count),
		.error        (error),
		.end_of_run   (end_of_run)
	);

	sparse_matrix_fast_transpose_chk u_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_wdata    (cfg_wdata),
		.start        (start),
		.busy         (busy),
		.term_row     (term_row),
		.term_col     (term_col),
		.term_value   (term_value),
		.has_term     (has_term),
		.last         (last),
		.result_valid (result_valid),
		.out_row      (out_row),
		.out_col      (out_col),
		.out_value    (out_value),
		.term_count   (term_count),
		.error        (error),
		.end_of_run   (end_of_run),
		.pending      (pending),
		.fail_count   (fail_count)
	);

	// 50 MHz clock
	initial begin
		forever #10 clk = ~clk;
	end

	// run limit
	initial begin
		#5ms;
		$display("** sparse_matrix_fast_transpose: FAILED **");
		$finish;
	end

	// one term beat after a random gap, held until the block takes it
	task automatic send_beat(input logic [IDX_W-1:0] r, input logic [IDX_W-1:0] c,
			input logic [VAL_W-1:0] v, input logic h, input logic l);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		term_row   <= r;
		term_col   <= c;
		term_value <= v;
		has_term   <= h;
		last       <= l;
		start      <= 1'b1;
		do @(posedge clk); while (busy);
		if (h || l)
			beats_sent++;
	endtask

	// hold off until every result is out and the block is idle
	task automatic wait_idle(input int settle);
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0 || busy)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	// write both dimension registers
	task automatic set_dims(input logic [DIM_W-1:0] rows, input logic [DIM_W-1:0] cols);
		start     <= 1'b0;
		cfg_we    <= 1'b1;
		cfg_idx   <= CFG_NUM_ROWS;
		cfg_wdata <= rows;
		@(posedge clk);
		cfg_idx   <= CFG_NUM_COLS;
		cfg_wdata <= cols;
		@(posedge clk);
		cfg_we    <= 1'b0;
		eff_rows = (int'(rows) < DEF_MAX_DIM) ? int'(rows) : DEF_MAX_DIM;
		eff_cols = (int'(cols) < DEF_MAX_DIM) ? int'(cols) : DEF_MAX_DIM;
	endtask

	// mostly legal sizes, sometimes zero or past the index range
	function automatic logic [DIM_W-1:0] pick_dim();
		case ($urandom_range(0, 9))
			0: begin
				return '0;
			end
			1: begin
				return DIM_W'($urandom_range(17, 31));
			end
			2: begin
				return DIM_W'(DEF_MAX_DIM);
			end
			default: begin
				return DIM_W'($urandom_range(1, DEF_MAX_DIM));
			end
		endcase
	endfunction

	initial begin
		int               len;
		int               kind;
		logic [IDX_W-1:0] r;
		logic [IDX_W-1:0] c;
		logic [VAL_W-1:0] v;
		logic             h;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset dimensions: extremes of value and index, stable order in a column
		send_beat(4'd0, 4'd0, 32'h8000_0000, 1'b1, 1'b0);
		send_beat(4'd15, 4'd15, 32'h7fff_ffff, 1'b1, 1'b0);
		send_beat(4'd3, 4'd15, 32'hffff_ffff, 1'b1, 1'b0);
		send_beat(4'd5, 4'd9, 32'h1234_5678, 1'b0, 1'b0);
		send_beat(4'd7, 4'd0, 32'h0000_0000, 1'b1, 1'b0);
		send_beat(4'd2, 4'd15, 32'ha5a5_a5a5, 1'b1, 1'b1);
		wait_idle(4);

		// bad row, bad column, one good term, end marker without a term
		set_dims(5'd4, 5'd3);
		send_beat(4'd4, 4'd0, 32'h0000_0001, 1'b1, 1'b0);
		send_beat(4'd0, 4'd3, 32'h0000_0002, 1'b1, 1'b0);
		send_beat(4'd3, 4'd2, 32'h5a5a_5a5a, 1'b1, 1'b0);
		send_beat(4'd9, 4'd9, 32'hdead_beef, 1'b0, 1'b1);

		// empty load
		send_beat(4'd0, 4'd0, 32'h0, 1'b0, 1'b1);
		wait_idle(4);

		// zero rows: every term dropped, so no results
		set_dims(5'd0, 5'd16);
		send_beat(4'd0, 4'd0, 32'h1111_1111, 1'b1, 1'b0);
		send_beat(4'd1, 4'd1, 32'h2222_2222, 1'b1, 1'b1);
		wait_idle(4);

		// oversized registers clip to the index range, then shrink inside the load
		set_dims(5'd31, 5'd17);
		send_beat(4'd15, 4'd15, 32'hcafe_f00d, 1'b1, 1'b0);
		set_dims(5'd8, 5'd16);
		send_beat(4'd10, 4'd2, 32'h0bad_0bad, 1'b1, 1'b0);
		send_beat(4'd1, 4'd1, 32'h0000_00ff, 1'b1, 1'b1);
		wait_idle(4);

		// smallest matrix
		set_dims(5'd1, 5'd1);
		send_beat(4'd0, 4'd0, 32'h8000_0001, 1'b1, 1'b1);
		wait_idle(4);
		set_dims(5'd16, 5'd16);

		// random loads
		while (beats_sent < 430) begin
			if ($urandom_range(0, 3) == 0) begin
				wait_idle(4);
				set_dims(pick_dim(), pick_dim());
			end
			burst = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 24) == 0)
				len = $urandom_range(60, 72);
			else
				len = $urandom_range(1, 12);
			for (int k = 0; k < len; k++) begin
				kind = $urandom_range(0, 19);
				r = (eff_rows > 0) ? IDX_W'($urandom_range(0, eff_rows - 1))
					: IDX_W'($urandom_range(0, 15));
				c = (eff_cols > 0) ? IDX_W'($urandom_range(0, eff_cols - 1))
					: IDX_W'($urandom_range(0, 15));
				v = $urandom;
				h = 1'b1;
				// out-of-range index
				if (kind <= 1) begin
					if (eff_rows < DEF_MAX_DIM)
						r = IDX_W'($urandom_range(eff_rows, 15));
					else if (eff_cols < DEF_MAX_DIM)
						c = IDX_W'($urandom_range(eff_cols, 15));
				end
				// beat without a term
				if (kind == 2)
					h = 1'b0;
				// value extremes
				if (kind == 3) begin
					case ($urandom_range(0, 3))
						0: v = 32'h8000_0000;
						1: v = 32'h7fff_ffff;
						2: v = 32'h0000_0000;
						default: v = 32'hffff_ffff;
					endcase
				end
				send_beat(r, c, v, h, (k == len - 1));
			end
			if ($urandom_range(0, 9) == 0)
				send_beat(IDX_W'($urandom), IDX_W'($urandom), $urandom, 1'b0, 1'b1);
		end

		// drain and let any stray beat show up
		burst = 1'b0;
		wait_idle(200);
		if (fail_count == 0) begin
			$display("** sparse_matrix_fast_transpose: PASSED **");
		end else begin
			$display("** sparse_matrix_fast_transpose: FAILED **");
		end
		$finish;
	end

endmodule

/* files.f */
sv/smft_pkg.sv
sv/smft_ctrl.sv
sv/smft_dp.sv
sv/sparse_matrix_fast_transpose.sv
test/sparse_matrix_fast_transpose_chk.sv
test/sparse_matrix_fast_transpose_tb.sv
